// File: rtl/ppc_pkg.sv
// ppc_pkg: shared types, constants and functions of the perfect power classifier
// used by the root cells and the top level; no dependencies

package ppc_pkg;

  localparam int unsigned VALUE_BITS   = 31;
  localparam int unsigned MASK_BITS    = 30;
  localparam int unsigned CNT_W        = 5;
  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(4);

  // square root cells: two radicand bits per cell
  localparam int unsigned SQ_XW    = 32;
  localparam int unsigned SQ_RW    = 20;
  localparam int unsigned SQ_YW    = 16;
  localparam int unsigned SQ_CELLS = 30;
  localparam int unsigned SQ_B     = 16;  // root of the root
  localparam int unsigned SQ_C     = 24;
  localparam int unsigned SQ_D     = 28;

  // cube root cells: three radicand bits per cell
  localparam int unsigned CB_XW    = 33;
  localparam int unsigned CB_RW    = 28;
  localparam int unsigned CB_YW    = 12;
  localparam int unsigned CB_Y2W   = 24;
  localparam int unsigned CB_CELLS = 17;
  localparam int unsigned CB_B     = 11;
  localparam int unsigned CB_C     = 15;

  localparam int unsigned PIPE_DEPTH   = SQ_CELLS;
  localparam int unsigned TAB_MAX_BASE = 73;
  localparam int unsigned TAB_N        = 10;
  localparam int unsigned TAB_EXP [TAB_N] = '{5, 7, 11, 13, 17, 19, 23, 25, 29, 31};

  typedef struct packed {
    logic [SQ_XW-1:0] x;
    logic [SQ_RW-1:0] r;
    logic [SQ_YW-1:0] y;
  } sq_t;

  typedef struct packed {
    logic [CB_XW-1:0]  x;
    logic [CB_RW-1:0]  r;
    logic [CB_YW-1:0]  y;
    logic [CB_Y2W-1:0] y2;
  } cb_t;

  typedef struct packed {
    logic        one;
    logic        zero;
    logic        sq2;
    logic        sq4;
    logic        sq8;
    logic        sq16;
    logic        cu3;
    logic        cu9;
    logic        cu27;
    logic [31:0] tab;  // indexed by exponent, set for the listed larger exponents
  } flags_t;

  // value equals b^e for some base 2..TAB_MAX_BASE; powers are folded at elaboration
  function automatic logic pow_hit(logic [VALUE_BITS-1:0] v, int unsigned e);
    logic [63:0] p;
    logic        hit;
    hit = 1'b0;
    for (int unsigned b = 2; b <= TAB_MAX_BASE; b++) begin
      p = 64'd1;
      for (int unsigned i = 0; i < 32; i++) begin
        if (i < e && p < (64'd1 << VALUE_BITS)) begin
          p = p * 64'(b);
        end
      end
      if (p < (64'd1 << VALUE_BITS) && v == p[VALUE_BITS-1:0]) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  // bit k: value is a (k+2)-th power, built from the prime power parts of the exponent
  function automatic logic [MASK_BITS-1:0] mask_of(flags_t f, logic [CNT_W-1:0] cnt);
    logic [MASK_BITS-1:0] m;
    int unsigned          rem;
    int unsigned          t2;
    int unsigned          t3;
    logic                 ok;
    m = '0;
    for (int unsigned k = 0; k < MASK_BITS; k++) begin
      rem = k + 2;
      t2  = 1;
      t3  = 1;
      for (int unsigned i = 0; i < 5; i++) begin
        if (rem % 2 == 0) begin
          rem = rem / 2;
          t2  = t2 * 2;
        end
      end
      for (int unsigned i = 0; i < 3; i++) begin
        if (rem % 3 == 0) begin
          rem = rem / 3;
          t3  = t3 * 3;
        end
      end
      ok = 1'b1;
      case (t2)
        2:       ok = ok & f.sq2;
        4:       ok = ok & f.sq4;
        8:       ok = ok & f.sq8;
        16:      ok = ok & f.sq16;
        default: ok = ok;
      endcase
      case (t3)
        3:       ok = ok & f.cu3;
        9:       ok = ok & f.cu9;
        27:      ok = ok & f.cu27;
        default: ok = ok;
      endcase
      if (rem > 1) begin
        ok = ok & f.tab[rem[4:0]];
      end
      m[k] = (CNT_W'(k) < cnt) && (f.one || (!f.zero && ok));
    end
    return m;
  endfunction

endpackage

// File: rtl/ppc_sqrt_cell.sv
// ppc_sqrt_cell: one digit step of a restoring square root, registered
// depends on ppc_pkg

module ppc_sqrt_cell
  import ppc_pkg::*;
(
  input  logic clk_i,
  input  logic en_i,
  input  sq_t  cell_i,
  output sq_t  cell_o
);

  logic [SQ_RW-1:0] rs;
  logic [SQ_RW-1:0] t;
  sq_t              cell_d;
  sq_t              cell_q;

  always_comb begin
    rs       = {cell_i.r[SQ_RW-3:0], cell_i.x[SQ_XW-1 -: 2]};
    t        = {2'b00, cell_i.y, 2'b01};
    cell_d.x = {cell_i.x[SQ_XW-3:0], 2'b00};
    if (rs >= t) begin
      cell_d.r = rs - t;
      cell_d.y = {cell_i.y[SQ_YW-2:0], 1'b1};
    end else begin
      cell_d.r = rs;
      cell_d.y = {cell_i.y[SQ_YW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

// File: rtl/ppc_cbrt_cell.sv
// ppc_cbrt_cell: one digit step of a restoring cube root, registered
// depends on ppc_pkg

module ppc_cbrt_cell
  import ppc_pkg::*;
(
  input  logic clk_i,
  input  logic en_i,
  input  cb_t  cell_i,
  output cb_t  cell_o
);

  logic [CB_RW-1:0] rs;
  logic [CB_RW-1:0] t;
  logic [CB_RW-1:0] y2e;
  logic [CB_RW-1:0] ye;
  cb_t              cell_d;
  cb_t              cell_q;

  always_comb begin
    rs  = {cell_i.r[CB_RW-4:0], cell_i.x[CB_XW-1 -: 3]};
    y2e = {4'b0, cell_i.y2};
    ye  = {16'b0, cell_i.y};
    // (2y+1)^3 - (2y)^3
    t   = (y2e << 3) + (y2e << 2) + (ye << 2) + (ye << 1) + CB_RW'(1);
    cell_d.x = {cell_i.x[CB_XW-4:0], 3'b000};
    if (rs >= t) begin
      cell_d.r  = rs - t;
      cell_d.y  = {cell_i.y[CB_YW-2:0], 1'b1};
      cell_d.y2 = {cell_i.y2[CB_Y2W-3:0], 2'b00} + {10'b0, cell_i.y, 2'b00} + CB_Y2W'(1);
    end else begin
      cell_d.r  = rs;
      cell_d.y  = {cell_i.y[CB_YW-2:0], 1'b0};
      cell_d.y2 = {cell_i.y2[CB_Y2W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

// File: rtl/perfect_power_classifier.sv
// perfect_power_classifier: top level, chains of root cells plus flag pipeline
// depends on ppc_pkg, ppc_sqrt_cell, ppc_cbrt_cell

// Takes one value per cycle and returns, for each input transfer, a mask
// whose bit k says whether the value is a perfect (k+2)-th power; bits at or above
// exponent_count read zero, the value one sets every enabled bit and zero sets none.
// The latency is set by the longest root chain: four nested square-root sections of
// 16, 8, 4 and 2 cells, followed by the output register. Cube tests run in a parallel
// chain of 11, 4 and 2 cells, larger exponents free of 2 and 3 are matched against constant
// powers at the input. Sustained rate is one transfer per cycle; the pipeline holds
// only when a finished result waits at the output and another reaches the last stage.

module perfect_power_classifier
  import ppc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,   // exponent_count
  input  logic             s_tvalid_i,
  output logic             s_tready_o,
  input  logic [31:0]      s_tdata_i,     // [30:0] value
  output logic             m_tvalid_o,
  input  logic             m_tready_i,
  output logic [31:0]      m_tdata_o      // [29:0] power_mask
);

  logic [CNT_W-1:0]      cnt_q;
  logic [PIPE_DEPTH-1:0] valid_q;
  flags_t                flags_q [PIPE_DEPTH];
  flags_t                flags_d [PIPE_DEPTH];
  flags_t                flags_fin;
  sq_t                   sq_in [SQ_CELLS];
  sq_t                   sq_o  [SQ_CELLS];
  cb_t                   cb_in [CB_CELLS];
  cb_t                   cb_o  [CB_CELLS];
  logic                  en;
  logic                  m_valid_q;
  logic [MASK_BITS-1:0]  m_mask_q;
  logic [VALUE_BITS-1:0] v;

  assign v          = s_tdata_i[VALUE_BITS-1:0];
  assign en         = !(m_valid_q && !m_tready_i && valid_q[PIPE_DEPTH-1]);
  assign s_tready_o = en;
  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = {{(32-MASK_BITS){1'b0}}, m_mask_q};

  // square root chain, reseeded with the previous root at each section boundary
  always_comb begin
    sq_in[0] = '{x: {1'b0, v}, r: '0, y: '0};
    for (int unsigned k = 1; k < SQ_CELLS; k++) begin
      if (k == SQ_B) begin
        sq_in[k] = '{x: {sq_o[k-1].y, 16'b0}, r: '0, y: '0};
      end else if (k == SQ_C) begin
        sq_in[k] = '{x: {sq_o[k-1].y[7:0], 24'b0}, r: '0, y: '0};
      end else if (k == SQ_D) begin
        sq_in[k] = '{x: {sq_o[k-1].y[3:0], 28'b0}, r: '0, y: '0};
      end else begin
        sq_in[k] = sq_o[k-1];
      end
    end
  end

  always_comb begin
    cb_in[0] = '{x: {2'b0, v}, r: '0, y: '0, y2: '0};
    for (int unsigned k = 1; k < CB_CELLS; k++) begin
      if (k == CB_B) begin
        cb_in[k] = '{x: {1'b0, cb_o[k-1].y[10:0], 21'b0}, r: '0, y: '0, y2: '0};
      end else if (k == CB_C) begin
        cb_in[k] = '{x: {2'b0, cb_o[k-1].y[3:0], 27'b0}, r: '0, y: '0, y2: '0};
      end else begin
        cb_in[k] = cb_o[k-1];
      end
    end
  end

  for (genvar g = 0; g < SQ_CELLS; g++) begin : g_sq
    ppc_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .cell_i (sq_in[g]),
      .cell_o (sq_o[g])
    );
  end

  for (genvar g = 0; g < CB_CELLS; g++) begin : g_cb
    ppc_cbrt_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .cell_i (cb_in[g]),
      .cell_o (cb_o[g])
    );
  end

  // flags ride along; each root section drops its verdict in when it finishes
  always_comb begin
    flags_d[0]      = '0;
    flags_d[0].one  = (v == VALUE_BITS'(1));
    flags_d[0].zero = (v == '0);
    for (int unsigned i = 0; i < TAB_N; i++) begin
      flags_d[0].tab[TAB_EXP[i]] = pow_hit(v, TAB_EXP[i]);
    end
    for (int unsigned k = 1; k < PIPE_DEPTH; k++) begin
      flags_d[k] = flags_q[k-1];
      if (k == SQ_B) flags_d[k].sq2 = (sq_o[k-1].r == '0);
      if (k == SQ_C) flags_d[k].sq4 = flags_q[k-1].sq2 && (sq_o[k-1].r == '0);
      if (k == SQ_D) flags_d[k].sq8 = flags_q[k-1].sq4 && (sq_o[k-1].r == '0);
      if (k == CB_B) flags_d[k].cu3 = (cb_o[k-1].r == '0);
      if (k == CB_C) flags_d[k].cu9 = flags_q[k-1].cu3 && (cb_o[k-1].r == '0);
      if (k == CB_CELLS) flags_d[k].cu27 = flags_q[k-1].cu9 && (cb_o[k-1].r == '0);
    end
    flags_fin      = flags_q[PIPE_DEPTH-1];
    flags_fin.sq16 = flags_fin.sq8 && (sq_o[SQ_CELLS-1].r == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int unsigned k = 0; k < PIPE_DEPTH; k++) begin
        flags_q[k] <= flags_d[k];
      end
    end
    if (en && valid_q[PIPE_DEPTH-1]) begin
      m_mask_q <= mask_of(flags_fin, cnt_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= CNT_RESET;
      valid_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cnt_q <= cfg_wdata_i;
      end
      if (en) begin
        valid_q <= {valid_q[PIPE_DEPTH-2:0], s_tvalid_i};
      end
      if (en && valid_q[PIPE_DEPTH-1]) begin
        m_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_tready_i && valid_q[PIPE_DEPTH-1]) |-> !s_tready_o)
    else $error("pipeline advanced over a waiting result");

  a_mask_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> ((m_mask_q >> cnt_q) == '0))
    else $error("mask bit beyond exponent count");

  a_fourth_sq : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_mask_q[2]) |-> m_mask_q[0])
    else $error("fourth power without square");

  a_sixth : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_mask_q[4]) |-> (m_mask_q[0] && m_mask_q[1]))
    else $error("sixth power without square and cube");

endmodule
